### rtl/omtml_pkg.sv
package omtml_pkg;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_COEF_X        = 3'd0,
    REG_COEF_Y        = 3'd1,
    REG_COEF_Z        = 3'd2,
    REG_TORQUE_LIMIT  = 3'd3,
    REG_FILTER_GAIN   = 3'd4,
    REG_TIMEOUT_TICKS = 3'd5
  } reg_index_t;

  // Operation codes of an input word
  localparam logic OP_COMMAND = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  // Register reset values
  localparam logic [15:0] RST_COEF_X        = 16'd3822;
  localparam logic [15:0] RST_COEF_Y        = 16'd2206;
  localparam logic [15:0] RST_COEF_Z        = 16'd17170;
  localparam logic [14:0] RST_TORQUE_LIMIT  = 15'd19251;
  localparam logic [15:0] RST_FILTER_GAIN   = 16'd655;
  localparam logic [15:0] RST_TIMEOUT_TICKS = 16'd200;

  // Gain of one in Q1.15; larger register values act as this
  localparam logic [15:0] GAIN_ONE = 16'h8000;

  // Tick counter saturates here
  localparam logic [16:0] TICK_SAT = 17'h1FFFF;

  // Clamp a wide signed torque to +-lim and return it in Q4.12
  function automatic logic signed [15:0] clamp_torque(input logic signed [23:0] v,
                                                      input logic [14:0] lim);
    logic signed [23:0] lim_pos;
    logic signed [23:0] lim_neg;
    logic signed [23:0] res;
    lim_pos = signed'({9'b0, lim});
    lim_neg = -lim_pos;
    if (v > lim_pos) begin
      res = lim_pos;
    end else if (v < lim_neg) begin
      res = lim_neg;
    end else begin
      res = v;
    end
    return res[15:0];
  endfunction

endpackage

### rtl/omniwheel_torque_mix_lag.sv
// Three-wheel omni drive torque mixer with a first-order lag on the applied
// wheel torques.
//
// Input channel (in_valid / in_ready): one word per item. operation 0 is a
// wrench command (force_x, force_y, yaw_torque) that sets the held wheel
// targets; operation 1 is a control tick that steps the applied torques.
// Output channel (out_valid / out_ready): one word per input word with the
// applied left, right and back torques and the timeout flag.
// Configuration: cfg_write with cfg_index and cfg_data writes one register
// in the same cycle; write only while the block is idle.
//
// An accepted word enters the input register; the mixer or lag multipliers
// then feed the result register, which raises out_valid. A stalled receiver
// can hold the word in the input register. Throughput is one word per cycle
// while the receiver does not stall; each word sees the state left by the one
// before it. When the receiver stalls, the result register holds and the
// input register still takes one more word, after which in_ready drops.
// Synchronous reset loads the register defaults, clears targets, applied
// torques, the command flag and the tick count, and empties both stages.
module omniwheel_torque_mix_lag (
  input  logic               clk,
  input  logic               rst,
  // configuration write port
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic signed [15:0] force_x,
  input  logic signed [15:0] force_y,
  input  logic signed [15:0] yaw_torque,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] torque_left,
  output logic signed [15:0] torque_right,
  output logic signed [15:0] torque_back,
  output logic               timed_out
);

  // configuration registers
  logic [15:0] coef_x;
  logic [15:0] coef_y;
  logic [15:0] coef_z;
  logic [14:0] torque_limit;
  logic [15:0] filter_gain;
  logic [15:0] timeout_ticks;

  // input stage
  logic               s1_valid;
  logic               s1_op;
  logic signed [15:0] s1_fx;
  logic signed [15:0] s1_fy;
  logic signed [15:0] s1_tz;

  // block state: index 0 left, 1 right, 2 back
  logic signed [15:0] target [3];
  logic signed [15:0] applied [3];
  logic               command_seen;
  logic [16:0]        ticks;

  logic in_take;
  logic advance;

  // mixer signals
  logic signed [32:0] prod_x;
  logic signed [32:0] prod_y;
  logic signed [32:0] prod_z;
  logic signed [39:0] px;
  logic signed [39:0] py;
  logic signed [39:0] py2;
  logic signed [39:0] pz;
  logic signed [39:0] sum_l;
  logic signed [39:0] sum_r;
  logic signed [39:0] sum_b;
  logic signed [15:0] mix [3];

  // lag signals
  logic [15:0]        alpha;
  logic [16:0]        ticks_next;
  logic               tick_timed;
  logic signed [15:0] desired [3];
  logic signed [16:0] err [3];
  logic signed [33:0] lag_prod [3];
  logic signed [33:0] lag_rnd [3];
  logic signed [19:0] lag_sum [3];
  logic signed [15:0] upd [3];

  // handshake
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || !out_valid || out_ready;
  assign in_take  = in_valid && in_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_x        <= omtml_pkg::RST_COEF_X;
      coef_y        <= omtml_pkg::RST_COEF_Y;
      coef_z        <= omtml_pkg::RST_COEF_Z;
      torque_limit  <= omtml_pkg::RST_TORQUE_LIMIT;
      filter_gain   <= omtml_pkg::RST_FILTER_GAIN;
      timeout_ticks <= omtml_pkg::RST_TIMEOUT_TICKS;
    end else if (cfg_write) begin
      case (cfg_index)
        omtml_pkg::REG_COEF_X:        coef_x        <= cfg_data;
        omtml_pkg::REG_COEF_Y:        coef_y        <= cfg_data;
        omtml_pkg::REG_COEF_Z:        coef_z        <= cfg_data;
        omtml_pkg::REG_TORQUE_LIMIT:  torque_limit  <= cfg_data[14:0];
        omtml_pkg::REG_FILTER_GAIN:   filter_gain   <= cfg_data;
        omtml_pkg::REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // wrench mixer: Q0.16 coefficients times Q8.8 forces and Q4.12 torque, in Q.28
  always_comb begin
    prod_x = signed'({1'b0, coef_x}) * s1_fx;
    prod_y = signed'({1'b0, coef_y}) * s1_fy;
    prod_z = signed'({1'b0, coef_z}) * s1_tz;
    px     = {{3{prod_x[32]}}, prod_x, 4'b0};
    py     = {{3{prod_y[32]}}, prod_y, 4'b0};
    py2    = {py[38:0], 1'b0};
    pz     = {{7{prod_z[32]}}, prod_z};
    // round half up, then floor shift to Q4.12
    sum_l  = px + py + pz + 40'sd32768;
    sum_r  = pz + py - px + 40'sd32768;
    sum_b  = pz - py2 + 40'sd32768;
    mix[0] = omtml_pkg::clamp_torque(sum_l[39:16], torque_limit);
    mix[1] = omtml_pkg::clamp_torque(sum_r[39:16], torque_limit);
    mix[2] = omtml_pkg::clamp_torque(sum_b[39:16], torque_limit);
  end

  // tick count and timeout
  always_comb begin
    ticks_next = (ticks != omtml_pkg::TICK_SAT) ? ticks + 17'd1 : ticks;
    tick_timed = !command_seen || (ticks_next > {1'b0, timeout_ticks});
    alpha      = (filter_gain > omtml_pkg::GAIN_ONE) ? omtml_pkg::GAIN_ONE : filter_gain;
  end

  // first-order lag per wheel
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      desired[i]  = tick_timed ? 16'sd0 : target[i];
      err[i]      = {desired[i][15], desired[i]} - {applied[i][15], applied[i]};
      lag_prod[i] = signed'({1'b0, alpha}) * err[i];
      lag_rnd[i]  = lag_prod[i] + 34'sd16384;
      lag_sum[i]  = {{4{applied[i][15]}}, applied[i]}
                  + {lag_rnd[i][33], lag_rnd[i][33:15]};
      upd[i]      = omtml_pkg::clamp_torque({{4{lag_sum[i][19]}}, lag_sum[i]}, torque_limit);
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (in_take) begin
      s1_op <= operation;
      s1_fx <= force_x;
      s1_fy <= force_y;
      s1_tz <= yaw_torque;
    end
  end

  // state update and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      command_seen <= 1'b0;
      ticks        <= '0;
      for (int i = 0; i < 3; i++) begin
        target[i]  <= '0;
        applied[i] <= '0;
      end
    end else begin
      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (advance) begin
        if (s1_op == omtml_pkg::OP_COMMAND) begin
          for (int i = 0; i < 3; i++) begin
            target[i] <= mix[i];
          end
          ticks        <= '0;
          command_seen <= 1'b1;
        end else begin
          for (int i = 0; i < 3; i++) begin
            applied[i] <= upd[i];
          end
          ticks <= ticks_next;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (advance) begin
      if (s1_op == omtml_pkg::OP_COMMAND) begin
        torque_left  <= applied[0];
        torque_right <= applied[1];
        torque_back  <= applied[2];
        timed_out    <= 1'b0;
      end else begin
        torque_left  <= upd[0];
        torque_right <= upd[1];
        torque_back  <= upd[2];
        timed_out    <= tick_timed;
      end
    end
  end

  // a tick before any command always reports a timeout
  a_tick_no_command: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_op == omtml_pkg::OP_TICK && !command_seen) |=> (out_valid && timed_out))
    else $error("tick without a prior command did not time out");

  // a command restarts the tick count and never reports a timeout
  a_command_clears: assert property (@(posedge clk) disable iff (rst)
    (advance && s1_op == omtml_pkg::OP_COMMAND) |=> (command_seen && ticks == '0 && !timed_out))
    else $error("command did not restart the tick count");

  // input stalls only when both stages hold words
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && out_valid && !out_ready))
    else $error("input stalled with room in the pipeline");

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

  // Indexes past the last register; writes there must be dropped
  localparam logic [2:0] REG_SPARE_6 = 3'd6;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  // Cycles with work pending but no word moving on either channel
  localparam int STALL_LIMIT = 5000;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    logic               op;
    logic signed [15:0] fx;
    logic signed [15:0] fy;
    logic signed [15:0] tz;
    bit                 drain;   // hold this word until all results are back
  } wrench_word_t;

  typedef struct {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic signed [15:0] back;
    logic               timed;
  } wheel_out_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = omtml_pkg::REG_COEF_X;
  logic [15:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               operation = omtml_pkg::OP_TICK;
  logic signed [15:0] force_x = '0;
  logic signed [15:0] force_y = '0;
  logic signed [15:0] yaw_torque = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] torque_left;
  logic signed [15:0] torque_right;
  logic signed [15:0] torque_back;
  logic               timed_out;

  omniwheel_torque_mix_lag uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .operation    (operation),
    .force_x      (force_x),
    .force_y      (force_y),
    .yaw_torque   (yaw_torque),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .torque_left  (torque_left),
    .torque_right (torque_right),
    .torque_back  (torque_back),
    .timed_out    (timed_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor copy of the registers
  logic [15:0] k_x       = omtml_pkg::RST_COEF_X;
  logic [15:0] k_y       = omtml_pkg::RST_COEF_Y;
  logic [15:0] k_z       = omtml_pkg::RST_COEF_Z;
  logic [14:0] k_limit   = omtml_pkg::RST_TORQUE_LIMIT;
  logic [15:0] k_gain    = omtml_pkg::RST_FILTER_GAIN;
  logic [15:0] k_timeout = omtml_pkg::RST_TIMEOUT_TICKS;

  // Predictor copy of the wheel state: left, right, back
  longint      wheel_target [3] = '{0, 0, 0};
  longint      wheel_applied[3] = '{0, 0, 0};
  bit          cmd_seen = 1'b0;
  logic [16:0] tick_count = '0;

  wrench_word_t pending_words[$];
  wheel_out_t   expected_torques[$];

  int  idle_pct = 0;
  int  stall_pct = 0;
  bit  in_took = 1'b0;
  int  bad_count = 0;
  int  result_count = 0;
  int  stall_cycles = 0;

  function automatic longint clamp_to_limit(longint v);
    longint lim;
    lim = longint'(k_limit);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Mixer on commands, first-order lag on ticks
  function automatic wheel_out_t predict_wheel_torques(wrench_word_t w);
    wheel_out_t r;
    longint     px, py, pz, alpha, want, err, delta;
    bit         timed;
    timed = 1'b0;
    if (w.op == omtml_pkg::OP_COMMAND) begin
      px = longint'(k_x) * longint'(w.fx) * 16;
      py = longint'(k_y) * longint'(w.fy) * 16;
      pz = longint'(k_z) * longint'(w.tz);
      wheel_target[0] = clamp_to_limit((px + py + pz + 32768) >>> 16);
      wheel_target[1] = clamp_to_limit((-px + py + pz + 32768) >>> 16);
      wheel_target[2] = clamp_to_limit((-2 * py + pz + 32768) >>> 16);
      tick_count = '0;
      cmd_seen = 1'b1;
    end else begin
      alpha = (k_gain > omtml_pkg::GAIN_ONE) ? longint'(omtml_pkg::GAIN_ONE)
                                             : longint'(k_gain);
      if (tick_count < omtml_pkg::TICK_SAT) tick_count++;
      timed = !cmd_seen || (tick_count > {1'b0, k_timeout});
      for (int i = 0; i < 3; i++) begin
        want = timed ? 0 : wheel_target[i];
        err = want - wheel_applied[i];
        delta = (alpha * err + 16384) >>> 15;
        wheel_applied[i] = clamp_to_limit(wheel_applied[i] + delta);
      end
    end
    r.left  = 16'(wheel_applied[0]);
    r.right = 16'(wheel_applied[1]);
    r.back  = 16'(wheel_applied[2]);
    r.timed = timed;
    return r;
  endfunction

  task automatic report_bad(string what, wheel_out_t e);
    bad_count++;
    if (bad_count <= MAX_REPORTS) begin
      $display("result %0d %s: expected L=%0d R=%0d B=%0d to=%0b, got L=%0d R=%0d B=%0d to=%0b",
               result_count, what, e.left, e.right, e.back, e.timed,
               torque_left, torque_right, torque_back, timed_out);
    end
  endtask

  // Driver: new word at the falling edge once the previous one is taken
  always @(negedge clk) begin
    wrench_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      if (!in_valid || in_took) begin
        if (pending_words.size() != 0 &&
            !(pending_words[0].drain && expected_torques.size() != 0) &&
            int'($urandom_range(99)) >= idle_pct) begin
          w = pending_words.pop_front();
          in_valid   <= 1'b1;
          operation  <= w.op;
          force_x    <= w.fx;
          force_y    <= w.fy;
          yaw_torque <= w.tz;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= (int'($urandom_range(99)) >= stall_pct);
    end
  end

  // Monitor: check results, predict on accepted words, watchdog
  always @(posedge clk) begin
    wheel_out_t   e;
    wrench_word_t w;
    bit           moved;
    if (rst) begin
      in_took = 1'b0;
    end else begin
      in_took = in_valid && in_ready;
      moved = in_took;
      if (out_valid && out_ready) begin
        moved = 1'b1;
        if (expected_torques.size() == 0) begin
          e = '{default: '0};
          report_bad("arrived with nothing expected", e);
        end else begin
          e = expected_torques.pop_front();
          if (torque_left !== e.left || torque_right !== e.right ||
              torque_back !== e.back || timed_out !== e.timed)
            report_bad("differs", e);
        end
        result_count++;
      end
      if (in_took) begin
        w.op = operation;
        w.fx = force_x;
        w.fy = force_y;
        w.tz = yaw_torque;
        w.drain = 1'b0;
        expected_torques.push_back(predict_wheel_torques(w));
      end
      if (moved)
        stall_cycles = 0;
      else if (pending_words.size() != 0 || expected_torques.size() != 0 || in_valid)
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("omniwheel_torque_mix_lag: mismatch");
        $finish;
      end
    end
  end

  // Register write; predictor copy follows at once since the block is idle
  task automatic set_reg(logic [2:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      omtml_pkg::REG_COEF_X:        k_x = val;
      omtml_pkg::REG_COEF_Y:        k_y = val;
      omtml_pkg::REG_COEF_Z:        k_z = val;
      omtml_pkg::REG_TORQUE_LIMIT:  k_limit = val[14:0];
      omtml_pkg::REG_FILTER_GAIN:   k_gain = val;
      omtml_pkg::REG_TIMEOUT_TICKS: k_timeout = val;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_words.size() != 0 || expected_torques.size() != 0 || in_valid);
    repeat (4) @(posedge clk);
  endtask

  function automatic void push_word(logic op, logic signed [15:0] fx,
                                    logic signed [15:0] fy, logic signed [15:0] tz,
                                    bit drain = 1'b0);
    wrench_word_t w;
    w.op = op;
    w.fx = fx;
    w.fy = fy;
    w.tz = tz;
    w.drain = drain;
    pending_words.push_back(w);
  endfunction

  function automatic logic signed [15:0] pick_field();
    case ($urandom_range(7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      3: return 16'(int'($urandom_range(128)) - 64);
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_coef();
    case ($urandom_range(5))
      0: return '0;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // Bit 15 is dropped by the block; toggle it anyway
  function automatic logic [15:0] pick_limit();
    logic [14:0] lim;
    case ($urandom_range(7))
      0: lim = '0;
      1: lim = 15'h7FFF;
      2: lim = 15'($urandom_range(64, 1));
      default: lim = 15'($urandom_range(32767));
    endcase
    return {1'($urandom_range(1)), lim};
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(7))
      0: return '0;
      1: return omtml_pkg::GAIN_ONE;
      2: return 16'hFFFF;
      3: return 16'($urandom_range(65535, 32769));
      default: return 16'($urandom_range(32768));
    endcase
  endfunction

  function automatic logic [15:0] pick_timeout();
    case ($urandom_range(5))
      0: return '0;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(24));
    endcase
  endfunction

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: tick before any command, extreme wrenches, ignored fields
    push_word(omtml_pkg::OP_TICK, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    push_word(omtml_pkg::OP_COMMAND, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    push_word(omtml_pkg::OP_TICK, '0, '0, '0);
    push_word(omtml_pkg::OP_TICK, '0, '0, '0);
    push_word(omtml_pkg::OP_COMMAND, 16'sh8000, 16'sh8000, 16'sh8000);
    push_word(omtml_pkg::OP_TICK, 16'sh8000, 16'sh7FFF, 16'sh8000);
    push_word(omtml_pkg::OP_TICK, '0, '0, '0);
    push_word(omtml_pkg::OP_COMMAND, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    push_word(omtml_pkg::OP_TICK, '0, '0, '0);
    push_word(omtml_pkg::OP_COMMAND, '0, '0, '0);
    push_word(omtml_pkg::OP_TICK, '0, '0, '0, 1'b1);
    wait_drained();

    // Largest coefficients and limit, gain above one, timeout every tick
    set_reg(omtml_pkg::REG_COEF_X, 16'hFFFF);
    set_reg(omtml_pkg::REG_COEF_Y, 16'hFFFF);
    set_reg(omtml_pkg::REG_COEF_Z, 16'hFFFF);
    set_reg(omtml_pkg::REG_TORQUE_LIMIT, 16'hFFFF);
    set_reg(omtml_pkg::REG_FILTER_GAIN, 16'hFFFF);
    set_reg(omtml_pkg::REG_TIMEOUT_TICKS, '0);
    set_reg(REG_SPARE_6, '0);
    set_reg(REG_SPARE_7, 16'h0001);
    end_writes();
    push_word(omtml_pkg::OP_COMMAND, 16'sh8000, 16'sh7FFF, 16'sh8000);
    push_word(omtml_pkg::OP_TICK, '0, '0, '0);
    push_word(omtml_pkg::OP_TICK, '0, '0, '0);
    wait_drained();

    // Held targets come back once the timeout is lifted
    set_reg(omtml_pkg::REG_TIMEOUT_TICKS, 16'hFFFF);
    set_reg(omtml_pkg::REG_FILTER_GAIN, omtml_pkg::GAIN_ONE);
    end_writes();
    push_word(omtml_pkg::OP_TICK, '0, '0, '0);
    push_word(omtml_pkg::OP_TICK, '0, '0, '0);
    wait_drained();

    // Zero limit clamps the applied torques; zero coefficients
    set_reg(omtml_pkg::REG_TORQUE_LIMIT, '0);
    set_reg(omtml_pkg::REG_COEF_X, '0);
    set_reg(omtml_pkg::REG_COEF_Y, '0);
    set_reg(omtml_pkg::REG_COEF_Z, '0);
    end_writes();
    push_word(omtml_pkg::OP_TICK, '0, '0, '0);
    push_word(omtml_pkg::OP_COMMAND, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    push_word(omtml_pkg::OP_TICK, '0, '0, '0);
    wait_drained();

    // Zero gain leaves applied torques in place
    set_reg(omtml_pkg::REG_TORQUE_LIMIT, 16'd4096);
    set_reg(omtml_pkg::REG_COEF_X, omtml_pkg::RST_COEF_X);
    set_reg(omtml_pkg::REG_COEF_Y, omtml_pkg::RST_COEF_Y);
    set_reg(omtml_pkg::REG_COEF_Z, omtml_pkg::RST_COEF_Z);
    set_reg(omtml_pkg::REG_FILTER_GAIN, '0);
    end_writes();
    push_word(omtml_pkg::OP_COMMAND, 16'sh1234, 16'shE000, 16'sh4000);
    push_word(omtml_pkg::OP_TICK, '0, '0, '0);
    wait_drained();

    // Run of ticks crosses a short timeout, then a new command rearms it
    set_reg(omtml_pkg::REG_TORQUE_LIMIT, 16'h7FFF);
    set_reg(omtml_pkg::REG_FILTER_GAIN, omtml_pkg::GAIN_ONE);
    set_reg(omtml_pkg::REG_TIMEOUT_TICKS, 16'd8);
    end_writes();
    push_word(omtml_pkg::OP_COMMAND, pick_field(), pick_field(), pick_field());
    for (int i = 0; i < 20; i++)
      push_word(omtml_pkg::OP_TICK, pick_field(), pick_field(), '0);
    push_word(omtml_pkg::OP_COMMAND, pick_field(), pick_field(), pick_field());
    push_word(omtml_pkg::OP_TICK, '0, '0, '0);
    wait_drained();

    // Random phases, each with fresh settings and its own pacing
    for (int p = 0; p < 8; p++) begin
      set_reg(omtml_pkg::REG_COEF_X, pick_coef());
      set_reg(omtml_pkg::REG_COEF_Y, pick_coef());
      set_reg(omtml_pkg::REG_COEF_Z, pick_coef());
      set_reg(omtml_pkg::REG_TORQUE_LIMIT, pick_limit());
      set_reg(omtml_pkg::REG_FILTER_GAIN, pick_gain());
      set_reg(omtml_pkg::REG_TIMEOUT_TICKS, pick_timeout());
      end_writes();
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 57; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 57; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      for (int i = 0; i < 126; i++) begin
        push_word(($urandom_range(99) < 25) ? omtml_pkg::OP_COMMAND : omtml_pkg::OP_TICK,
                  pick_field(), pick_field(), pick_field(),
                  $urandom_range(99) == 0);
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (bad_count == 0 && expected_torques.size() == 0)
      $display("omniwheel_torque_mix_lag: match");
    else
      $display("omniwheel_torque_mix_lag: mismatch");
    $finish;
  end

endmodule

### filelist.f
rtl/omtml_pkg.sv
rtl/omniwheel_torque_mix_lag.sv
dv/testbench.sv
